// File: rtl/gdwl_pkg.sv
package gdwl_pkg;

  typedef struct packed {
    logic               action;
    logic [15:0]        cell_index;
    logic signed [15:0] cell_value;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
  } gdwl_in_t;

  typedef struct packed {
    logic signed [23:0] mean_value;
    logic               good;
  } gdwl_out_t;

  typedef struct packed {
    logic signed [31:0] x_lower_left;
    logic signed [31:0] y_lower_left;
    logic [23:0]        cell_size;
    logic [8:0]         num_cols;
    logic [8:0]         num_rows;
    logic signed [15:0] null_value;
  } gdwl_cfg_t;

  localparam logic [2:0] REG_X_LL      = 3'd0;
  localparam logic [2:0] REG_Y_LL      = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_NUM_COLS  = 3'd3;
  localparam logic [2:0] REG_NUM_ROWS  = 3'd4;
  localparam logic [2:0] REG_NULL      = 3'd5;

  localparam logic signed [31:0] RST_X_LL      = 32'sd0;
  localparam logic signed [31:0] RST_Y_LL      = 32'sd0;
  localparam logic [23:0]        RST_CELL_SIZE = 24'd256;
  localparam logic [8:0]         RST_NUM_COLS  = 9'd256;
  localparam logic [8:0]         RST_NUM_ROWS  = 9'd256;
  localparam logic signed [15:0] RST_NULL      = -16'sd9999;

  localparam logic [4:0] COORD_LAST_STEP = 5'd8;
  localparam logic [4:0] ROOT_LAST_STEP  = 5'd31;
  localparam logic [4:0] MEAN_LAST_STEP  = 5'd23;

  typedef enum logic [3:0] {
    OP_IDLE, OP_PREP, OP_CHECK, OP_DIVX, OP_DIVY, OP_GEOM, OP_SQ, OP_ADDR,
    OP_READ, OP_VAL, OP_ROOT, OP_MAC, OP_FINIT, OP_FDIV, OP_DONE
  } gdwl_op_t;

  typedef struct packed {
    logic       wr;
    logic       load;
    gdwl_op_t   op;
    logic [1:0] nb;
    logic       last;
  } gdwl_cmd_t;

  typedef struct packed {
    logic outside;
    logic qualify;
    logic wzero;
  } gdwl_status_t;

endpackage

// File: rtl/gdwl_ctrl.sv
module gdwl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  action,
  output logic                  busy,
  output logic                  result_valid,
  output gdwl_pkg::gdwl_cmd_t    cmd,
  input  gdwl_pkg::gdwl_status_t status
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_PREP  = 15'b000000000000010,
    S_CHECK = 15'b000000000000100,
    S_DIVX  = 15'b000000000001000,
    S_DIVY  = 15'b000000000010000,
    S_GEOM  = 15'b000000000100000,
    S_SQ    = 15'b000000001000000,
    S_ADDR  = 15'b000000010000000,
    S_READ  = 15'b000000100000000,
    S_VAL   = 15'b000001000000000,
    S_ROOT  = 15'b000010000000000,
    S_MAC   = 15'b000100000000000,
    S_FINIT = 15'b001000000000000,
    S_FDIV  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] step, step_next;
  logic [1:0] nb, nb_next;
  logic       last;

  assign last         = (step == 5'd0);
  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    step_next  = step;
    nb_next    = nb;
    cmd.wr     = 1'b0;
    cmd.load   = 1'b0;
    cmd.op     = gdwl_pkg::OP_IDLE;
    cmd.nb     = nb;
    cmd.last   = last;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (action) begin
            cmd.load   = 1'b1;
            state_next = S_PREP;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_PREP: begin
        cmd.op     = gdwl_pkg::OP_PREP;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.op    = gdwl_pkg::OP_CHECK;
        step_next = gdwl_pkg::COORD_LAST_STEP;
        state_next = status.outside ? S_DONE : S_DIVX;
      end
      S_DIVX: begin
        cmd.op = gdwl_pkg::OP_DIVX;
        if (last) begin
          step_next  = gdwl_pkg::COORD_LAST_STEP;
          state_next = S_DIVY;
        end else begin
          step_next = step - 5'd1;
        end
      end
      S_DIVY: begin
        cmd.op = gdwl_pkg::OP_DIVY;
        if (last) begin
          state_next = S_GEOM;
        end else begin
          step_next = step - 5'd1;
        end
      end
      S_GEOM: begin
        cmd.op     = gdwl_pkg::OP_GEOM;
        step_next  = 5'd0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op    = gdwl_pkg::OP_SQ;
        cmd.nb    = step[1:0];
        step_next = step + 5'd1;
        if (step[1:0] == 2'd3) begin
          nb_next    = 2'd0;
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.op     = gdwl_pkg::OP_ADDR;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.op     = gdwl_pkg::OP_READ;
        state_next = S_VAL;
      end
      S_VAL: begin
        cmd.op = gdwl_pkg::OP_VAL;
        if (status.qualify) begin
          step_next  = gdwl_pkg::ROOT_LAST_STEP;
          state_next = S_ROOT;
        end else if (nb == 2'd3) begin
          state_next = S_FINIT;
        end else begin
          nb_next    = nb + 2'd1;
          state_next = S_ADDR;
        end
      end
      S_ROOT: begin
        cmd.op = gdwl_pkg::OP_ROOT;
        if (last) begin
          state_next = S_MAC;
        end else begin
          step_next = step - 5'd1;
        end
      end
      S_MAC: begin
        cmd.op = gdwl_pkg::OP_MAC;
        if (nb == 2'd3) begin
          state_next = S_FINIT;
        end else begin
          nb_next    = nb + 2'd1;
          state_next = S_ADDR;
        end
      end
      S_FINIT: begin
        cmd.op     = gdwl_pkg::OP_FINIT;
        step_next  = gdwl_pkg::MEAN_LAST_STEP;
        state_next = status.wzero ? S_DONE : S_FDIV;
      end
      S_FDIV: begin
        cmd.op = gdwl_pkg::OP_FDIV;
        if (last) begin
          state_next = S_DONE;
        end else begin
          step_next = step - 5'd1;
        end
      end
      S_DONE: begin
        cmd.op     = gdwl_pkg::OP_DONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 5'd0;
      nb    <= 2'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
      nb    <= nb_next;
    end
  end

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> state == S_IDLE) else $error("result strobe held");

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && !action) |=> !busy) else $error("write left block busy");

  a_root_to_mac: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && last) |=> state == S_MAC) else $error("root did not finish");

endmodule

// File: rtl/gdwl_dp.sv
module gdwl_dp #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gdwl_pkg::gdwl_cfg_t    cfg,
  input  gdwl_pkg::gdwl_in_t     req,
  input  gdwl_pkg::gdwl_cmd_t    cmd,
  output gdwl_pkg::gdwl_status_t status,
  output gdwl_pkg::gdwl_out_t    res
);

  logic [15:0] mem [65536];
  logic signed [15:0] rdata;

  logic [8:0] cols_eff, rows_eff;
  logic signed [31:0] x_q;
  logic signed [32:0] y_q;
  logic [32:0] xspan, yspan;
  logic signed [33:0] dxo, dyo;

  logic [32:0] drem, drem_n;
  logic [31:0] dsh;
  logic [8:0]  dq, dq_n;
  logic        dge;

  logic [8:0]  col, row;
  logic [23:0] remx, remy;
  logic [24:0] dxn, dyn;
  logic [25:0] dxf, dyf;
  logic [9:0]  cfar, rfar;
  logic [51:0] sxn, sxf, syn, syf;

  logic [24:0] twox, twoy, cs25;
  logic [25:0] cs3;
  logic        ltx, lty;
  logic [25:0] dsel;
  logic [9:0]  rsel, csel;
  logic [17:0] addr18;
  logic        inb;
  logic        inb_q;
  logic [15:0] addr_q;
  logic [51:0] sqx, sqy;

  logic signed [15:0] vq;
  logic [63:0] rad;
  logic [32:0] rrem;
  logic [31:0] root;
  logic [34:0] rt, rtrial;
  logic        rge;

  logic signed [50:0] acc;
  logic signed [48:0] prod;
  logic [33:0] wsum;
  logic [49:0] mag;
  logic        neg_q;
  logic [58:0] frem, frem_n;
  logic [56:0] fsh;
  logic [23:0] fq, fq_n;
  logic        fge;

  assign cols_eff = (int'(cfg.num_cols) > MAX_COLS) ? 9'(MAX_COLS) : cfg.num_cols;
  assign rows_eff = (int'(cfg.num_rows) > MAX_ROWS) ? 9'(MAX_ROWS) : cfg.num_rows;

  // The point lies inside the rectangle when the cell size is not zero and both offsets are in [0, span].
  assign status.outside = (cfg.cell_size == 24'd0) || dxo[33] || dyo[33] ||
                          (dxo > $signed({1'b0, xspan})) || (dyo > $signed({1'b0, yspan}));
  assign status.qualify = inb_q && (rdata != cfg.null_value);
  assign status.wzero   = (wsum == 34'd0);

  assign dge    = drem >= {1'b0, dsh};
  assign drem_n = dge ? drem - {1'b0, dsh} : drem;
  assign dq_n   = {dq[7:0], dge};

  assign cs25 = {1'b0, cfg.cell_size};
  assign cs3  = {1'b0, cfg.cell_size, 1'b0} + {2'b0, cfg.cell_size};
  assign twox = {remx, 1'b0};
  assign twoy = {remy, 1'b0};
  assign ltx  = twox < cs25;
  assign lty  = twoy < cs25;

  always_comb begin
    case (cmd.nb)
      2'd0:    dsel = {1'b0, dxn};
      2'd1:    dsel = dxf;
      2'd2:    dsel = {1'b0, dyn};
      default: dsel = dyf;
    endcase
  end

  assign rsel   = cmd.nb[1] ? rfar : {1'b0, row};
  assign csel   = cmd.nb[0] ? cfar : {1'b0, col};
  assign addr18 = 18'(cols_eff) * 18'(rsel[8:0]) + 18'(csel[8:0]);
  assign inb    = !rsel[9] && !csel[9] && (rsel[8:0] < rows_eff) &&
                  (csel[8:0] < cols_eff) && (addr18[17:16] == 2'b00);

  assign sqx = cmd.nb[0] ? sxf : sxn;
  assign sqy = cmd.nb[1] ? syf : syn;

  // One result bit per cycle of the integer square root.
  assign rt     = {rrem, rad[63:62]};
  assign rtrial = {1'b0, root, 2'b01};
  assign rge    = rt >= rtrial;

  assign prod   = vq * $signed({1'b0, root});

  assign fge    = frem >= {2'b0, fsh};
  assign frem_n = fge ? frem - {2'b0, fsh} : frem;
  assign fq_n   = {fq[22:0], fge};
  assign mag    = acc[50] ? 50'(-acc) : 50'(acc);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[req.cell_index] <= req.cell_value;
    end
    rdata <= mem[addr_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_q <= req.x_pos;
      y_q <= -33'(req.y_pos);
    end
    case (cmd.op)
      gdwl_pkg::OP_PREP: begin
        xspan <= 33'(cfg.cell_size) * 33'(cols_eff);
        yspan <= 33'(cfg.cell_size) * 33'(rows_eff);
        dxo   <= 34'(x_q) - 34'(cfg.x_lower_left);
        dyo   <= 34'(y_q) - 34'(cfg.y_lower_left);
      end
      gdwl_pkg::OP_CHECK: begin
        res.mean_value <= 24'sd0;
        res.good       <= 1'b0;
        acc  <= 51'sd0;
        wsum <= 34'd0;
        drem <= dxo[32:0];
        dsh  <= {cfg.cell_size, 8'b0};
        dq   <= 9'd0;
      end
      gdwl_pkg::OP_DIVX: begin
        if (cmd.last) begin
          col  <= dq_n;
          remx <= drem_n[23:0];
          drem <= dyo[32:0];
          dsh  <= {cfg.cell_size, 8'b0};
          dq   <= 9'd0;
        end else begin
          drem <= drem_n;
          dsh  <= dsh >> 1;
          dq   <= dq_n;
        end
      end
      gdwl_pkg::OP_DIVY: begin
        if (cmd.last) begin
          row  <= dq_n;
          remy <= drem_n[23:0];
        end else begin
          drem <= drem_n;
          dsh  <= dsh >> 1;
          dq   <= dq_n;
        end
      end
      gdwl_pkg::OP_GEOM: begin
        // The far neighbours lie on the side of the centre that the point is on.
        dxn  <= ltx ? cs25 - twox : twox - cs25;
        dxf  <= ltx ? {1'b0, twox} + {2'b0, cfg.cell_size} : cs3 - {1'b0, twox};
        cfar <= ltx ? {1'b0, col} - 10'd1 : {1'b0, col} + 10'd1;
        dyn  <= lty ? cs25 - twoy : twoy - cs25;
        dyf  <= lty ? {1'b0, twoy} + {2'b0, cfg.cell_size} : cs3 - {1'b0, twoy};
        rfar <= lty ? {1'b0, row} - 10'd1 : {1'b0, row} + 10'd1;
      end
      gdwl_pkg::OP_SQ: begin
        case (cmd.nb)
          2'd0:    sxn <= dsel * dsel;
          2'd1:    sxf <= dsel * dsel;
          2'd2:    syn <= dsel * dsel;
          default: syf <= dsel * dsel;
        endcase
      end
      gdwl_pkg::OP_ADDR: begin
        inb_q  <= inb;
        addr_q <= addr18[15:0];
      end
      gdwl_pkg::OP_VAL: begin
        vq   <= rdata;
        rad  <= {1'b0, 53'(sqx) + 53'(sqy), 10'b0};
        rrem <= 33'd0;
        root <= 32'd0;
      end
      gdwl_pkg::OP_ROOT: begin
        rrem <= rge ? 33'(rt - rtrial) : 33'(rt);
        root <= {root[30:0], rge};
        rad  <= {rad[61:0], 2'b00};
      end
      gdwl_pkg::OP_MAC: begin
        acc  <= acc + 51'(prod);
        wsum <= wsum + 34'(root);
      end
      gdwl_pkg::OP_FINIT: begin
        neg_q <= acc[50];
        frem  <= {1'b0, mag, 8'b0} + 59'(wsum >> 1);
        fsh   <= {wsum, 23'b0};
        fq    <= 24'd0;
      end
      gdwl_pkg::OP_FDIV: begin
        frem <= frem_n;
        fsh  <= fsh >> 1;
        fq   <= fq_n;
        if (cmd.last) begin
          res.mean_value <= neg_q ? $signed(24'd0 - fq_n) : $signed(fq_n);
          res.good       <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_rem_below_cell: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == gdwl_pkg::OP_DIVX && cmd.last) |=> remx < cfg.cell_size)
    else $error("coordinate remainder not below cell size");

  a_mean_good: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == gdwl_pkg::OP_FDIV && cmd.last) |=> res.good)
    else $error("finished mean without good flag");

  a_wsum_cleared: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == gdwl_pkg::OP_CHECK) |=> wsum == 34'd0)
    else $error("weight sum not cleared for a new query");

endmodule

// File: rtl/grid_distance_weighted_lookup.sv
// A request with action 0 writes one grid cell and busy stays
// low, so writes may be issued back to back. A request with action 1 is a query:
// busy rises and stays high until the result, which comes early when the point is
// outside the grid. Otherwise up to four neighbour cells are read; each that holds
// data adds a bit-serial square root for its weight, one root bit per cycle, and
// a bit-serial division then forms the mean; when the gathered weight is zero the
// division is skipped. The result appears for exactly one cycle with result_valid;
// it cannot be held off, so the receiver must take it then.
// Cells must be written before any query reads them.
module grid_distance_weighted_lookup #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  gdwl_pkg::gdwl_in_t  req,
  output logic                result_valid,
  output gdwl_pkg::gdwl_out_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  gdwl_pkg::gdwl_cfg_t    cfg;
  gdwl_pkg::gdwl_cmd_t    cmd;
  gdwl_pkg::gdwl_status_t status;
  logic [2:0]             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_lower_left <= gdwl_pkg::RST_X_LL;
      cfg.y_lower_left <= gdwl_pkg::RST_Y_LL;
      cfg.cell_size    <= gdwl_pkg::RST_CELL_SIZE;
      cfg.num_cols     <= gdwl_pkg::RST_NUM_COLS;
      cfg.num_rows     <= gdwl_pkg::RST_NUM_ROWS;
      cfg.null_value   <= gdwl_pkg::RST_NULL;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        gdwl_pkg::REG_X_LL:      cfg.x_lower_left <= pwdata;
        gdwl_pkg::REG_Y_LL:      cfg.y_lower_left <= pwdata;
        gdwl_pkg::REG_CELL_SIZE: cfg.cell_size    <= pwdata[23:0];
        gdwl_pkg::REG_NUM_COLS:  cfg.num_cols     <= pwdata[8:0];
        gdwl_pkg::REG_NUM_ROWS:  cfg.num_rows     <= pwdata[8:0];
        gdwl_pkg::REG_NULL:      cfg.null_value   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gdwl_pkg::REG_X_LL:      prdata = cfg.x_lower_left;
      gdwl_pkg::REG_Y_LL:      prdata = cfg.y_lower_left;
      gdwl_pkg::REG_CELL_SIZE: prdata = {8'b0, cfg.cell_size};
      gdwl_pkg::REG_NUM_COLS:  prdata = {23'b0, cfg.num_cols};
      gdwl_pkg::REG_NUM_ROWS:  prdata = {23'b0, cfg.num_rows};
      gdwl_pkg::REG_NULL:      prdata = {16'b0, cfg.null_value};
      default:                 prdata = 32'd0;
    endcase
  end

  gdwl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (req.action),
    .busy         (busy),
    .result_valid (result_valid),
    .cmd          (cmd),
    .status       (status)
  );

  gdwl_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .res    (result)
  );

endmodule

// File: sim/grid_distance_weighted_lookup_tb.sv
module grid_distance_weighted_lookup_tb;

  localparam int  CLK_PERIOD = 12;
  localparam int  GRID_MAX   = 256;
  localparam longint CYCLE_LIMIT = 3_000_000;

  class lookup_scoreboard;
    logic [15:0] cells [65536];
    bit          written [65536];
    gdwl_pkg::gdwl_cfg_t   cfg;
    gdwl_pkg::gdwl_out_t   pending_means [$];
    int          errors;

    function new();
      cfg.x_lower_left = gdwl_pkg::RST_X_LL;
      cfg.y_lower_left = gdwl_pkg::RST_Y_LL;
      cfg.cell_size    = gdwl_pkg::RST_CELL_SIZE;
      cfg.num_cols     = gdwl_pkg::RST_NUM_COLS;
      cfg.num_rows     = gdwl_pkg::RST_NUM_ROWS;
      cfg.null_value   = gdwl_pkg::RST_NULL;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        gdwl_pkg::REG_X_LL:      cfg.x_lower_left = val;
        gdwl_pkg::REG_Y_LL:      cfg.y_lower_left = val;
        gdwl_pkg::REG_CELL_SIZE: cfg.cell_size    = val[23:0];
        gdwl_pkg::REG_NUM_COLS:  cfg.num_cols     = val[8:0];
        gdwl_pkg::REG_NUM_ROWS:  cfg.num_rows     = val[8:0];
        gdwl_pkg::REG_NULL:      cfg.null_value   = val[15:0];
        default: ;
      endcase
    endfunction

    // Finds the in-bounds neighbour cells of a point and their centres in half coordinate units.
    function int grid_cells(longint x, longint y, output int addr[4],
                            output longint cx[4], output longint cy[4]);
      longint xll, yll, cs, cols, rows, col, row, lr, ud, r, c;
      longint rr[4], cc[4];
      int n;
      xll = longint'(cfg.x_lower_left);
      yll = longint'(cfg.y_lower_left);
      cs = longint'(cfg.cell_size);
      cols = (cfg.num_cols > GRID_MAX) ? GRID_MAX : longint'(cfg.num_cols);
      rows = (cfg.num_rows > GRID_MAX) ? GRID_MAX : longint'(cfg.num_rows);
      n = 0;
      if (cs == 0) return 0;
      if (x < xll || x > xll + cs * cols) return 0;
      if (y < yll || y > yll + cs * rows) return 0;
      col = (x - xll) / cs;
      row = (y - yll) / cs;
      lr = (2 * x < 2 * (col * cs + xll) + cs) ? -1 : 1;
      ud = (2 * y < 2 * (row * cs + yll) + cs) ? -1 : 1;
      rr = '{row, row, row + ud, row + ud};
      cc = '{col, col + lr, col, col + lr};
      for (int i = 0; i < 4; i++) begin
        r = rr[i];
        c = cc[i];
        if (r < 0 || c < 0 || r >= rows || c >= cols) continue;
        if (c + cols * r >= 65536) continue;
        addr[n] = int'(c + cols * r);
        cx[n] = 2 * (c * cs + xll) + cs;
        cy[n] = 2 * (r * cs + yll) + cs;
        n++;
      end
      return n;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function gdwl_pkg::gdwl_out_t weighted_mean(gdwl_pkg::gdwl_in_t q);
      gdwl_pkg::gdwl_out_t res;
      int addr[4];
      longint cx[4], cy[4];
      longint x, y, v, acc;
      longint unsigned dx, dy, w, wsum, mag, quo;
      int n;
      res = '0;
      x = longint'(q.x_pos);
      y = -longint'(q.y_pos);
      n = grid_cells(x, y, addr, cx, cy);
      acc = 0;
      wsum = 0;
      for (int i = 0; i < n; i++) begin
        v = longint'($signed(cells[addr[i]]));
        if (v == longint'(cfg.null_value)) continue;
        dx = (2 * x >= cx[i]) ? 2 * x - cx[i] : cx[i] - 2 * x;
        dy = (2 * y >= cy[i]) ? 2 * y - cy[i] : cy[i] - 2 * y;
        w = int_sqrt((dx * dx + dy * dy) << 10);
        acc += v * longint'(w);
        wsum += w;
      end
      if (wsum == 0) return res;
      mag = ((acc < 0) ? -acc : acc) << 8;
      quo = (mag + wsum / 2) / wsum;
      if (acc < 0) quo = -quo;
      res.mean_value = quo[23:0];
      res.good = 1'b1;
      return res;
    endfunction

    function void note_request(gdwl_pkg::gdwl_in_t q);
      if (!q.action) begin
        cells[q.cell_index] = q.cell_value;
        written[q.cell_index] = 1'b1;
      end else begin
        pending_means.push_back(weighted_mean(q));
      end
    endfunction

    function void check_result(gdwl_pkg::gdwl_out_t got);
      gdwl_pkg::gdwl_out_t exp_res;
      if (pending_means.size() == 0) begin
        $error("unexpected result mean_value %0d good %0d", got.mean_value, got.good);
        errors++;
        return;
      end
      exp_res = pending_means.pop_front();
      if (got.mean_value !== exp_res.mean_value) begin
        $error("mean_value expected %0d got %0d", exp_res.mean_value, got.mean_value);
        errors++;
      end
      if (got.good !== exp_res.good) begin
        $error("good expected %0d got %0d", exp_res.good, got.good);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst, start, busy, result_valid;
  gdwl_pkg::gdwl_in_t    req;
  gdwl_pkg::gdwl_out_t   result;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  lookup_scoreboard sb = new();
  int     idle_pct;
  longint cycles;

  grid_distance_weighted_lookup dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL grid_distance_weighted_lookup");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  task automatic send(gdwl_pkg::gdwl_in_t item);
    start <= 1'b1;
    req <= item;
    do @(posedge clk); while (busy);
    sb.note_request(item);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_cell(int idx, logic [15:0] val);
    gdwl_pkg::gdwl_in_t item;
    item = '0;
    item.x_pos = $urandom();
    item.y_pos = $urandom();
    item.cell_index = idx[15:0];
    item.cell_value = val;
    send(item);
  endtask

  function automatic logic [15:0] cell_data();
    if ($urandom_range(99) < 15) return sb.cfg.null_value;
    case ($urandom_range(3))
      0: return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
      1: return 16'($urandom_range(200)) - 16'd100;
      default: return 16'($urandom());
    endcase
  endfunction

  // Every cell the query can read is written first.
  task automatic query(logic [31:0] xp, logic [31:0] yp);
    gdwl_pkg::gdwl_in_t item;
    int addr[4];
    longint cx[4], cy[4];
    int n;
    n = sb.grid_cells(longint'($signed(xp)), -longint'($signed(yp)), addr, cx, cy);
    for (int i = 0; i < n; i++)
      if (!sb.written[addr[i]] || $urandom_range(9) == 0) write_cell(addr[i], cell_data());
    item = '0;
    item.action = 1'b1;
    item.cell_index = 16'($urandom());
    item.cell_value = 16'($urandom());
    item.x_pos = xp;
    item.y_pos = yp;
    send(item);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_means.size() != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup_grid(logic [31:0] xll, logic [31:0] yll, logic [23:0] cs,
                            logic [8:0] cols, logic [8:0] rows, logic [15:0] nul);
    drain();
    cfg_write(gdwl_pkg::REG_X_LL, xll);
    cfg_write(gdwl_pkg::REG_Y_LL, yll);
    cfg_write(gdwl_pkg::REG_CELL_SIZE, {8'd0, cs});
    cfg_write(gdwl_pkg::REG_NUM_COLS, {23'd0, cols});
    cfg_write(gdwl_pkg::REG_NUM_ROWS, {23'd0, rows});
    cfg_write(gdwl_pkg::REG_NULL, {{16{nul[15]}}, nul});
  endtask

  // Picks a point mostly inside the grid, with edges, centres and wild values mixed in.
  task automatic random_query();
    longint xll, yll, cs, cols, rows, x, y;
    int pick;
    xll = longint'(sb.cfg.x_lower_left);
    yll = longint'(sb.cfg.y_lower_left);
    cs = longint'(sb.cfg.cell_size);
    cols = (sb.cfg.num_cols > GRID_MAX) ? GRID_MAX : longint'(sb.cfg.num_cols);
    rows = (sb.cfg.num_rows > GRID_MAX) ? GRID_MAX : longint'(sb.cfg.num_rows);
    pick = $urandom_range(99);
    if (pick < 8) begin
      query($urandom(), $urandom());
      return;
    end
    if (pick < 20) begin
      x = ($urandom_range(1)) ? xll : xll + cs * cols;
      y = ($urandom_range(1)) ? yll : yll + cs * rows;
      x += longint'($urandom_range(2)) - 1;
      y += longint'($urandom_range(2)) - 1;
    end else if (pick < 30 && cs > 0 && cs % 2 == 0) begin
      x = xll + cs * longint'($urandom_range(cols - 1)) + cs / 2;
      y = yll + cs * longint'($urandom_range(rows - 1)) + cs / 2;
    end else begin
      x = xll + (({$urandom(), $urandom()} & 64'h7fff_ffff_ffff) % (cs * cols + 1));
      y = yll + (({$urandom(), $urandom()} & 64'h7fff_ffff_ffff) % (cs * rows + 1));
    end
    query(x[31:0], -y[31:0]);
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 20) write_cell(int'($urandom_range(65535)), cell_data());
      else random_query();
    end
  endtask

  initial begin
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 20;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset grid, extreme values, edges and points outside.
    write_cell(0, 16'h7fff);
    write_cell(1, 16'h8000);
    write_cell(256, 16'hd8f1);
    write_cell(257, 16'h0001);
    write_cell(65535, 16'h8000);
    query(32'd128, -32'sd128);
    query(32'd256, -32'sd256);
    query(32'd0, 32'd0);
    query(-32'sd1, -32'sd10);
    query(32'd10, 32'd1);
    query(32'd65537, -32'sd10);
    query(32'd10, -32'sd65537);
    query(32'd65536, -32'sd65536);
    query(32'h7fffffff, 32'h80000000);
    query(32'h80000000, 32'h7fffffff);

    // One cell only: the point on its centre carries no weight.
    setup_grid(-32'sd1000, 32'sd500, 24'd300, 9'd1, 9'd1, 16'd0);
    write_cell(0, 16'd77);
    query(-32'sd850, -32'sd650);
    query(-32'sd849, -32'sd650);
    query(-32'sd700, -32'sd800);
    run_phase(100);

    setup_grid(-32'sd1000, 32'sd500, 24'd300, 9'd5, 9'd4, 16'd0);
    run_phase(200);
    setup_grid(32'h80000000, 32'h80000000, 24'hffffff, 9'd2, 9'd3, 16'h8000);
    run_phase(150);
    setup_grid(32'sd5, -32'sd7, 24'd0, 9'd4, 9'd4, 16'h7fff);
    run_phase(40);
    setup_grid(32'sd0, 32'sd0, 24'd256, 9'd0, 9'd0, 16'hd8f1);
    run_phase(40);

    idle_pct = 62;
    setup_grid(-32'sd32768, 32'sd1000, 24'd256, 9'd511, 9'd511, 16'h8000);
    run_phase(50);
    setup_grid(32'h7fffff00, 32'h7fff0000, 24'd257, 9'd3, 9'd2, 16'd3);
    run_phase(150);

    idle_pct = 0;
    setup_grid(32'sd100, -32'sd100, 24'd1, 9'd256, 9'd256, 16'd5);
    run_phase(50);
    for (int k = 0; k < 4; k++) begin
      setup_grid($urandom(), $urandom(), 24'($urandom_range(1, 4096)),
                 9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)), cell_data());
      run_phase(40);
    end

    drain();
    if (sb.errors == 0) begin
      $display("PASS grid_distance_weighted_lookup");
    end else begin
      $display("FAIL grid_distance_weighted_lookup");
    end
    $finish;
  end
endmodule
